### hw/rtl/ffdf_pkg.sv
// ffdf_pkg: widths and shared types for the direct-form FIR filter.
// No dependencies; used by ffdf_cell and fir_filter_direct_form_top.
package ffdf_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned PROD_W    = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W     = 35;
  localparam int unsigned NUM_COEFS = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // per-cycle enables handed from the top-level pipeline control to each cell
  typedef struct packed {
    logic shift_en;  // take the neighbor's sample into the history
    logic mul_en;    // load product register
  } cell_ctrl_t;

endpackage

### hw/rtl/ffdf_cell.sv
// ffdf_cell: one tap of the FIR chain (history sample register plus product register).
// Depends on ffdf_pkg.
module ffdf_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ffdf_pkg::cell_ctrl_t                  ctrl,
  input  logic signed [ffdf_pkg::SAMPLE_W-1:0]  hist_in,
  input  logic signed [ffdf_pkg::COEF_W-1:0]    coef,
  output logic signed [ffdf_pkg::SAMPLE_W-1:0]  hist_out,
  output logic signed [ffdf_pkg::PROD_W-1:0]    prod_out
);

  logic signed [ffdf_pkg::SAMPLE_W-1:0] hist_r;
  logic signed [ffdf_pkg::PROD_W-1:0]   prod_r;
  logic signed [ffdf_pkg::PROD_W-1:0]   prod_nxt;

  assign prod_nxt = hist_r * coef;

  // history is filter state: empty history means zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctrl.shift_en) begin
      hist_r <= hist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign hist_out = hist_r;
  assign prod_out = prod_r;

endmodule

### hw/rtl/fir_filter_direct_form_top.sv
// fir_filter_direct_form_top: FIR filter built as a chain of ffdf_cell taps.
// Depends on ffdf_pkg and ffdf_cell.
//
// Takes one signed 16-bit sample per item and returns one 35-bit Q.15 sum per
// item: coef_0 weights the oldest of the last TAPS samples, coef_(TAPS-1) the
// newest. Sample history starts as all zero after reset. Each tap holds one
// history sample and hands it to the next older tap on every accepted item.
// The block takes one item every cycle while in_stall is low; a sample
// passes the history shift, the product register in each tap, then a
// three-level adder tree into the sum register, so no path holds more than
// one multiply or three adds. A stall on the output backs up through the
// three stages to in_stall. Coefficients are
// written through cfg_we/cfg_index/cfg_wdata while the filter is idle; all
// eight registers are kept even when TAPS is smaller.
module fir_filter_direct_form_top #(
  parameter int unsigned TAPS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [ffdf_pkg::SAMPLE_W-1:0]     in_sample_in,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [ffdf_pkg::ACC_W-1:0]        out_filtered_out,
  input  logic                                     cfg_we,
  input  logic [ffdf_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [ffdf_pkg::COEF_W-1:0]              cfg_wdata
);

  logic signed [ffdf_pkg::COEF_W-1:0]   coef_r [ffdf_pkg::NUM_COEFS];
  logic                                 va_r;
  logic                                 vb_r;
  logic                                 vc_r;
  logic                                 adv_a;
  logic                                 adv_b;
  logic                                 adv_c;
  logic                                 sum_en;
  ffdf_pkg::cell_ctrl_t                 ctrl;
  logic signed [ffdf_pkg::SAMPLE_W-1:0] hist_chain [TAPS];
  logic signed [ffdf_pkg::PROD_W-1:0]   prod_chain [TAPS];
  logic signed [ffdf_pkg::ACC_W-1:0]    prod_pad [ffdf_pkg::NUM_COEFS];
  logic signed [ffdf_pkg::ACC_W-1:0]    sum_l1 [4];
  logic signed [ffdf_pkg::ACC_W-1:0]    sum_l2 [2];
  logic signed [ffdf_pkg::ACC_W-1:0]    sum_nxt;
  logic signed [ffdf_pkg::ACC_W-1:0]    sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ffdf_pkg::NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  // stage enables: a stage moves when empty or when the stage after it moves
  assign adv_c    = !vc_r || !out_stall;
  assign adv_b    = !vb_r || adv_c;
  assign adv_a    = !va_r || adv_b;
  assign in_stall = !adv_a;

  assign ctrl.shift_en = in_valid && adv_a;
  assign ctrl.mul_en   = va_r && adv_b;
  assign sum_en        = vb_r && adv_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= in_valid;
      if (adv_b) vb_r <= va_r;
      if (adv_c) vc_r <= vb_r;
    end
  end

  // tap 0 holds the oldest sample, the last tap the newest
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic signed [ffdf_pkg::SAMPLE_W-1:0] hist_in;
    if (k == TAPS - 1) begin : g_head
      assign hist_in = in_sample_in;
    end else begin : g_link
      assign hist_in = hist_chain[k+1];
    end
    ffdf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .hist_in  (hist_in),
      .coef     (coef_r[k]),
      .hist_out (hist_chain[k]),
      .prod_out (prod_chain[k])
    );
  end

  for (genvar k = 0; k < ffdf_pkg::NUM_COEFS; k++) begin : g_pad
    if (k < TAPS) begin : g_used
      assign prod_pad[k] = {{(ffdf_pkg::ACC_W - ffdf_pkg::PROD_W){prod_chain[k][ffdf_pkg::PROD_W-1]}},
                            prod_chain[k]};
    end else begin : g_unused
      assign prod_pad[k] = '0;
    end
  end

  assign sum_l1[0] = prod_pad[0] + prod_pad[1];
  assign sum_l1[1] = prod_pad[2] + prod_pad[3];
  assign sum_l1[2] = prod_pad[4] + prod_pad[5];
  assign sum_l1[3] = prod_pad[6] + prod_pad[7];
  assign sum_l2[0] = sum_l1[0] + sum_l1[1];
  assign sum_l2[1] = sum_l1[2] + sum_l1[3];
  assign sum_nxt   = sum_l2[0] + sum_l2[1];

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid        = vc_r;
  assign out_filtered_out = sum_r;

endmodule

### verif/tb_fir_filter_direct_form_top.sv
// Self-checking testbench for fir_filter_direct_form_top: random samples and
// coefficient sets, with an in-line filter predictor checked against every sum.
// Depends on ffdf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_fir_filter_direct_form_top;

  localparam int unsigned TAPS       = 8;
  localparam int unsigned PERIOD     = 8;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASE_LEN  = 140;

  logic                                 clk          = 1'b0;
  logic                                 rst_n        = 1'b0;
  logic                                 in_valid     = 1'b0;
  logic                                 in_stall;
  logic signed [ffdf_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic                                 out_valid;
  logic                                 out_stall    = 1'b0;
  logic signed [ffdf_pkg::ACC_W-1:0]    out_filtered_out;
  logic                                 cfg_we       = 1'b0;
  logic [ffdf_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [ffdf_pkg::COEF_W-1:0]          cfg_wdata    = '0;

  // predictor state
  logic signed [ffdf_pkg::COEF_W-1:0]   coef_q [ffdf_pkg::NUM_COEFS];
  logic signed [ffdf_pkg::SAMPLE_W-1:0] hist_q [ffdf_pkg::NUM_COEFS];
  int                                   next_slot = 0;

  logic signed [ffdf_pkg::SAMPLE_W-1:0] sample_queue [$];
  logic signed [ffdf_pkg::ACC_W-1:0]    expected_sums [$];
  logic signed [ffdf_pkg::ACC_W-1:0]    want;

  int  fault_count   = 0;
  int  samples_taken = 0;
  int  idle_cycles   = 0;
  int  tx_gap        = 0;
  int  tx_quiet      = 0;
  int  rx_quiet      = 0;
  int  stall_left    = 0;
  int  run_left      = 0;
  bit  in_taken      = 1'b0;
  bit  hold_all      = 1'b0;

  fir_filter_direct_form_top #(.TAPS(TAPS)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered_out (out_filtered_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a quiet stretch with none.
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(40, 160);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // 16-bit value biased toward the extremes and small magnitudes
  function automatic logic [ffdf_pkg::SAMPLE_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 16) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  // Shift one sample into the history and return the full-precision sum.
  function automatic logic signed [ffdf_pkg::ACC_W-1:0] fir_step(
    input logic signed [ffdf_pkg::SAMPLE_W-1:0] s
  );
    longint acc;
    int     k;
    acc = 0;
    hist_q[next_slot] = s;
    next_slot = (next_slot + 1) % TAPS;
    // slot after the newest is the oldest, weighted by coef 0
    for (int i = 0; i < TAPS; i++) begin
      k = (next_slot + i) % TAPS;
      acc += longint'(hist_q[k]) * longint'(coef_q[i]);
    end
    return acc[ffdf_pkg::ACC_W-1:0];
  endfunction

  task automatic note_fault(input string msg);
    if (fault_count < 10) $display("ERROR @%0t: %s", $time, msg);
    fault_count++;
  endtask

  task automatic load_coefs(input logic [ffdf_pkg::COEF_W-1:0] vals [ffdf_pkg::NUM_COEFS],
                            input logic [7:0] mask);
    for (int i = 0; i < ffdf_pkg::NUM_COEFS; i++) begin
      if (mask[i]) begin
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ffdf_pkg::CFG_IDX_W'(i);
        cfg_wdata <= vals[i];
      end
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued item has gone in and every sum has come back
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_taken)) begin
      // hold the offered item until it is taken
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (sample_queue.size() != 0) begin
      in_valid     <= 1'b1;
      in_sample_in <= sample_queue.pop_front();
      tx_gap = pick_gap(tx_quiet);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output stall pattern
  always @(negedge clk) begin
    bit st;
    st = 1'b0;
    if (stall_left == 0 && run_left == 0) begin
      stall_left = pick_gap(rx_quiet);
      run_left   = $urandom_range(1, 6);
    end
    if (stall_left > 0) begin
      st = 1'b1;
      stall_left--;
    end else begin
      run_left--;
    end
    out_stall <= st || hold_all;
  end

  // predictor and checker
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) coef_q[cfg_index] = cfg_wdata;
      if (in_valid && !in_stall) begin
        expected_sums.push_back(fir_step(in_sample_in));
        samples_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          note_fault($sformatf("sum %0d with nothing expected", out_filtered_out));
        end else begin
          want = expected_sums.pop_front();
          if (want !== out_filtered_out)
            note_fault($sformatf("sum mismatch: expected %0d, got %0d", want, out_filtered_out));
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("fir_filter_direct_form_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // long output hold mid-run so the pipeline fills and backs up to the input
  initial begin
    while (samples_taken < 250) @(posedge clk);
    hold_all = 1'b1;
    repeat (80) @(posedge clk);
    hold_all = 1'b0;
  end

  initial begin
    logic [ffdf_pkg::COEF_W-1:0] vals [ffdf_pkg::NUM_COEFS];
    logic [7:0]                  mask;
    for (int i = 0; i < ffdf_pkg::NUM_COEFS; i++) begin
      coef_q[i] = '0;
      hist_q[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset coefficients are zero, so the first sums are zero
    sample_queue.push_back(16'sh7fff);
    sample_queue.push_back(16'sh8000);
    drain();

    // all weights at the negative limit: largest magnitude sum, then the other extreme
    foreach (vals[i]) vals[i] = 16'h8000;
    load_coefs(vals, 8'hff);
    repeat (8) sample_queue.push_back(16'sh8000);
    repeat (8) sample_queue.push_back(16'sh7fff);
    drain();

    // distinct weights, impulse: sums walk from the newest weight to the oldest
    foreach (vals[i]) vals[i] = (i % 2) ? -16'(1111 * (i + 1)) : 16'(1111 * (i + 1));
    load_coefs(vals, 8'hff);
    sample_queue.push_back(16'sh0001);
    repeat (7) sample_queue.push_back(16'sh0000);
    sample_queue.push_back(16'shffff);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        foreach (vals[i]) vals[i] = 16'h7fff;
        mask = 8'hff;
      end else if (p == 4) begin
        foreach (vals[i]) vals[i] = (i % 2) ? 16'h7fff : 16'h8000;
        mask = 8'hff;
      end else begin
        foreach (vals[i]) vals[i] = rand_word();
        mask = 8'($urandom()) | (8'h01 << $urandom_range(0, 7));
      end
      load_coefs(vals, mask);
      repeat (PHASE_LEN) sample_queue.push_back(rand_word());
      drain();
    end

    repeat (10) @(posedge clk);
    if (expected_sums.size() != 0)
      note_fault($sformatf("%0d sums never came out", expected_sums.size()));
    if (fault_count == 0) begin
      $display("fir_filter_direct_form_top verification clean");
    end else begin
      $display("fir_filter_direct_form_top verification failed");
    end
    $finish;
  end

endmodule
